### hw/rtl/rgcs_pkg.sv
// Shared types, constants and helpers for the ray grid cell stepper.
// Used by rgcs_mul, rgcs_div and ray_grid_cell_stepper_top; no dependencies.
package rgcs_pkg;

	localparam int FRAC_BITS = 16;
	localparam int W = 32;
	// Form values of a point: sum of two floored Q.F products, with margin for offsets.
	localparam int FV_W = 66 - FRAC_BITS;
	// Magnitude of a form value of the direction.
	localparam int Q_W = 64 - FRAC_BITS;
	localparam int MA_W = Q_W;
	localparam int MB_W = W;
	localparam int MP_W = MA_W + MB_W;
	localparam int MCNT_W = $clog2(MB_W);
	localparam int DN_W = 64;
	localparam int DD_W = Q_W + 1;
	localparam int DR_W = DD_W + 1;
	localparam int DCNT_W = $clog2(DN_W);
	localparam int TOL_W = 34 - FRAC_BITS;

	localparam logic [1:0] KIND_LOAD = 2'd0;
	localparam logic [1:0] KIND_NEXT_CELL = 2'd1;
	localparam logic [1:0] KIND_FULL = 2'd2;
	localparam logic [1:0] KIND_HALF = 2'd3;

	// Low two bits of a register index select the field, bit 2 the family.
	localparam logic [1:0] FLD_COEF_A = 2'd0;
	localparam logic [1:0] FLD_COEF_B = 2'd1;
	localparam logic [1:0] FLD_OFFSET = 2'd2;
	localparam logic [1:0] FLD_SPACING = 2'd3;
	localparam int CFG_IDX_W = 3;

	localparam logic [W-1:0] ONE_Q = W'(1) << FRAC_BITS;

	typedef struct packed {
		logic [1:0]   kind;
		logic [W-1:0] start_x;
		logic [W-1:0] start_y;
		logic [W-1:0] dir_x;
		logic [W-1:0] dir_y;
	} item_t;

	typedef struct packed {
		logic [W-1:0] pos_x;
		logic [W-1:0] pos_y;
		logic         corner;
		logic         error;
	} result_t;

	typedef struct packed {
		logic            start;
		logic [MA_W-1:0] a;
		logic [MB_W-1:0] b;
	} mul_req_t;

	typedef struct packed {
		logic            done;
		logic [MP_W-1:0] p;
	} mul_rsp_t;

	typedef struct packed {
		logic            start;
		logic [DN_W-1:0] n;
		logic [DD_W-1:0] d;
	} div_req_t;

	typedef struct packed {
		logic            done;
		logic [DN_W-1:0] quo;
		logic [DR_W-1:0] rem;
	} div_rsp_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_CHECK,
		ST_FORM_GO,
		ST_FORM_WAIT,
		ST_PARALLEL,
		ST_MOD_GO,
		ST_MOD_WAIT,
		ST_CMP_GO,
		ST_CMP_WAIT,
		ST_MOVE_MUL_GO,
		ST_MOVE_MUL_WAIT,
		ST_MOVE_DIV_GO,
		ST_MOVE_DIV_WAIT,
		ST_FINISH
	} state_t;

	function automatic logic [W-1:0] mag32(input logic [W-1:0] v);
		return v[W-1] ? -v : v;
	endfunction

	function automatic logic [Q_W-1:0] magfv(input logic [FV_W-1:0] v);
		logic [FV_W-1:0] t;
		t = v[FV_W-1] ? -v : v;
		return t[Q_W-1:0];
	endfunction

endpackage

### hw/rtl/rgcs_mul.sv
// Bit-serial unsigned shift-add multiplier, one multiplier bit per cycle.
// Depends on rgcs_pkg for widths and request/response types.
module rgcs_mul (
	input  logic                clk,
	input  logic                arst_n,
	input  rgcs_pkg::mul_req_t  req,
	output rgcs_pkg::mul_rsp_t  rsp
);

	logic [rgcs_pkg::MA_W-1:0]   a_q;
	logic [rgcs_pkg::MP_W:0]     pr_q;
	logic [rgcs_pkg::MCNT_W-1:0] cnt_q;
	logic                        busy_q;
	logic                        done_q;
	logic [rgcs_pkg::MA_W:0]     sum;
	logic [rgcs_pkg::MP_W:0]     pr_nxt;

	always_comb begin
		sum = pr_q[rgcs_pkg::MP_W:rgcs_pkg::MB_W]
			+ (pr_q[0] ? {1'b0, a_q} : '0);
		pr_nxt = {sum, pr_q[rgcs_pkg::MB_W-1:0]} >> 1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			a_q <= '0;
			pr_q <= '0;
			cnt_q <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				a_q <= req.a;
				pr_q <= {{(rgcs_pkg::MA_W+1){1'b0}}, req.b};
				cnt_q <= '0;
				busy_q <= 1'b1;
			end else if (busy_q) begin
				pr_q <= pr_nxt;
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == rgcs_pkg::MCNT_W'(rgcs_pkg::MB_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign rsp.done = done_q;
	assign rsp.p = pr_q[rgcs_pkg::MP_W-1:0];

endmodule

### hw/rtl/rgcs_div.sv
// Bit-serial restoring divider, one quotient bit per cycle.
// Depends on rgcs_pkg for widths and request/response types.
module rgcs_div (
	input  logic                clk,
	input  logic                arst_n,
	input  rgcs_pkg::div_req_t  req,
	output rgcs_pkg::div_rsp_t  rsp
);

	logic [rgcs_pkg::DN_W-1:0]   n_q;
	logic [rgcs_pkg::DD_W-1:0]   d_q;
	logic [rgcs_pkg::DR_W-1:0]   rem_q;
	logic [rgcs_pkg::DCNT_W-1:0] cnt_q;
	logic                        busy_q;
	logic                        done_q;
	logic [rgcs_pkg::DR_W-1:0]   trial;
	logic                        fits;

	always_comb begin
		trial = {rem_q[rgcs_pkg::DR_W-2:0], n_q[rgcs_pkg::DN_W-1]};
		fits = trial >= {1'b0, d_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			n_q <= '0;
			d_q <= '0;
			rem_q <= '0;
			cnt_q <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				n_q <= req.n;
				d_q <= req.d;
				rem_q <= '0;
				cnt_q <= '0;
				busy_q <= 1'b1;
			end else if (busy_q) begin
				rem_q <= fits ? trial - {1'b0, d_q} : trial;
				n_q <= {n_q[rgcs_pkg::DN_W-2:0], fits};
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == rgcs_pkg::DCNT_W'(rgcs_pkg::DN_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign rsp.done = done_q;
	assign rsp.quo = n_q;
	assign rsp.rem = rem_q;

endmodule

### hw/rtl/ray_grid_cell_stepper_top.sv
// Ray grid cell stepper: sequencer, configuration and ray state registers.
// Depends on rgcs_pkg, rgcs_mul and rgcs_div.
//
// Usage: the item channel (item_valid/item_ready/item) carries one beat per
// command: load a ray, step to the next cell, or make a full or half move to
// the next grid-line crossing. The result channel (result_valid/result_ready/
// result) returns exactly one beat per item with the ray start after the item
// and the corner and error flags. The eight family registers are written
// through cfg_we/cfg_index/cfg_data; the user must write them only while the
// block is idle, as the block itself does not enforce it. A load goes straight
// to the finish state, which fills the output register once it is free; the
// block returns to idle as it does so. A move runs every multiplication
// through a one-bit-per-cycle multiplier and every division and modulo
// through a one-bit-per-cycle divider, all on one shared pair of units. A move
// with both families in play costs 12 multiplications and 4 divisions; a
// next-cell step does two moves unless the first ends on a corner; a move with
// one family takes 8 multiplications and 3 divisions.
// One item is worked on at a time; item_ready is high only while idle.
// The finished result sits in an output register, so a stalled receiver
// holds only that beat: the next item is accepted and computed, and waits
// in its final state until the register frees up.
// Reset puts the family registers at the unit square grid, clears the ray
// to zero and empties the output register.
module ray_grid_cell_stepper_top (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                item_valid,
	output logic                                item_ready,
	input  rgcs_pkg::item_t                     item,
	output logic                                result_valid,
	input  logic                                result_ready,
	output rgcs_pkg::result_t                   result,
	input  logic                                cfg_we,
	input  logic [rgcs_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [rgcs_pkg::W-1:0]              cfg_data
);

	localparam int W = rgcs_pkg::W;
	localparam int FV_W = rgcs_pkg::FV_W;

	rgcs_pkg::state_t state_q, state_d;

	// Family registers, index 0 is the first family.
	logic [W-1:0] coef_a_q [2];
	logic [W-1:0] coef_b_q [2];
	logic [W-1:0] offset_q [2];
	logic [W-1:0] spacing_q [2];

	// Ray state.
	logic [W-1:0] sx_q, sy_q, dx_q, dy_q;

	// Sequencer working registers.
	logic            fam_q;       // family being worked on
	logic            term_q;      // 0: a*x term, 1: b*y term
	logic            phase_fs_q;  // 0: form of direction, 1: form of start
	logic            axis_q;      // 0: x, 1: y
	logic            cmp_q;       // second cross product pending
	logic            pass_q;      // second (half) move of a next-cell step
	logic            half_q;
	logic            next_cell_q;
	logic            corner_q;
	logic            err_q;
	logic [1:0]      used_q;      // families not parallel to the direction
	logic            sel_q;       // family that sets the move
	logic            ddneg_q;
	logic [FV_W-1:0] acc_q;
	logic [FV_W-1:0] fd_q [2];
	logic [W-1:0]    m_q [2];
	logic [rgcs_pkg::MP_W-1:0] p1_q;

	logic              result_valid_q;
	rgcs_pkg::result_t result_q;

	rgcs_pkg::mul_req_t mul_req;
	rgcs_pkg::mul_rsp_t mul_rsp;
	rgcs_pkg::div_req_t div_req;
	rgcs_pkg::div_rsp_t div_rsp;

	rgcs_mul u_mul (.clk(clk), .arst_n(arst_n), .req(mul_req), .rsp(mul_rsp));
	rgcs_div u_div (.clk(clk), .arst_n(arst_n), .req(div_req), .rsp(div_rsp));

	// Per-family selections.
	logic [W-1:0]    a_f, b_f, off_f, sp_f, ds_f;
	logic [FV_W-1:0] fd_f;
	logic [W-1:0]    coef, vcomp, dir_ax, pos_ax, m_sel;
	logic            term_neg;
	logic signed [63:0] term_s, term_sh;
	logic [FV_W-1:0] acc_nxt;
	logic [FV_W-1:0] d_v, dd_v, dd_mag;
	logic [W:0]      absum;
	logic [rgcs_pkg::TOL_W-1:0] tol;
	logic [W-1:0]    u_rem, r_v, m0_v, m_new;
	logic            up;
	logic            bad;
	logic            item_acc;
	logic            fin_load;
	logic            next_more;
	logic [rgcs_pkg::Q_W-1:0] q_sel;
	logic signed [65:0] pos_w, pos_sum;
	logic [W-1:0]    pos_sat;
	logic            p_lt, p_eq;

	always_comb begin
		a_f = fam_q ? coef_a_q[1] : coef_a_q[0];
		b_f = fam_q ? coef_b_q[1] : coef_b_q[0];
		off_f = fam_q ? offset_q[1] : offset_q[0];
		sp_f = fam_q ? spacing_q[1] : spacing_q[0];
		fd_f = fam_q ? fd_q[1] : fd_q[0];
		ds_f = rgcs_pkg::mag32(sp_f);

		// One term of a form value: signed product, floored to Q.F.
		coef = term_q ? b_f : a_f;
		vcomp = term_q ? (phase_fs_q ? sy_q : dy_q) : (phase_fs_q ? sx_q : dx_q);
		term_neg = coef[W-1] ^ vcomp[W-1];
		term_s = term_neg ? -$signed(mul_rsp.p[63:0]) : $signed(mul_rsp.p[63:0]);
		term_sh = term_s >>> rgcs_pkg::FRAC_BITS;
		acc_nxt = acc_q + term_sh[FV_W-1:0];

		// Signed distance from line zero, mirrored for a negative spacing.
		d_v = acc_q - {{(FV_W-W){off_f[W-1]}}, off_f};
		dd_v = sp_f[W-1] ? -d_v : d_v;
		dd_mag = dd_v[FV_W-1] ? -dd_v : dd_v;

		// Distance to the next line ahead, from the remainder of |dd| / |sp|.
		absum = {1'b0, rgcs_pkg::mag32(a_f)} + {1'b0, rgcs_pkg::mag32(b_f)};
		tol = rgcs_pkg::TOL_W'(absum >> rgcs_pkg::FRAC_BITS) + rgcs_pkg::TOL_W'(3);
		u_rem = div_rsp.rem[W-1:0];
		r_v = (ddneg_q && u_rem != '0) ? ds_f - u_rem : u_rem;
		up = (sp_f[W-1] == 1'b0) == (fd_f[FV_W-1] == 1'b0);
		m0_v = up ? ((r_v == '0) ? '0 : ds_f - r_v) : r_v;
		// A ray sitting on a line takes the following line instead.
		m_new = (m0_v <= W'(tol)) ? m0_v + ds_f : m0_v;

		bad = (dx_q == '0 && dy_q == '0) || spacing_q[0] == '0 || spacing_q[1] == '0;

		// Move of one coordinate by sign(dir) * floor(|dir| * m / q), with q doubled for a half move.
		dir_ax = axis_q ? dy_q : dx_q;
		pos_ax = axis_q ? sy_q : sx_q;
		m_sel = sel_q ? m_q[1] : m_q[0];
		q_sel = rgcs_pkg::magfv(sel_q ? fd_q[1] : fd_q[0]);
		pos_w = {{(66-W){pos_ax[W-1]}}, pos_ax};
		pos_sum = dir_ax[W-1] ? pos_w - $signed({2'b00, div_rsp.quo})
			: pos_w + $signed({2'b00, div_rsp.quo});
		if (pos_sum > 66'sd2147483647) begin
			pos_sat = {1'b0, {(W-1){1'b1}}};
		end else if (pos_sum < -66'sd2147483648) begin
			pos_sat = {1'b1, {(W-1){1'b0}}};
		end else begin
			pos_sat = pos_sum[W-1:0];
		end

		// Cross-multiplied comparison of the two ray parameters.
		p_lt = p1_q < mul_rsp.p;
		p_eq = p1_q == mul_rsp.p;

		item_acc = item_valid && item_ready;
		fin_load = (state_q == rgcs_pkg::ST_FINISH) && (!result_valid_q || result_ready);
		next_more = next_cell_q && !pass_q && !corner_q;
	end

	// Next-state logic.
	always_comb begin
		state_d = state_q;
		case (state_q)
			rgcs_pkg::ST_IDLE: begin
				if (item_valid) begin
					state_d = (item.kind == rgcs_pkg::KIND_LOAD) ? rgcs_pkg::ST_FINISH
						: rgcs_pkg::ST_CHECK;
				end
			end
			rgcs_pkg::ST_CHECK: begin
				state_d = bad ? rgcs_pkg::ST_FINISH : rgcs_pkg::ST_FORM_GO;
			end
			rgcs_pkg::ST_FORM_GO: state_d = rgcs_pkg::ST_FORM_WAIT;
			rgcs_pkg::ST_FORM_WAIT: begin
				if (mul_rsp.done) begin
					if (!term_q) begin
						state_d = rgcs_pkg::ST_FORM_GO;
					end else if (!phase_fs_q) begin
						state_d = fam_q ? rgcs_pkg::ST_PARALLEL : rgcs_pkg::ST_FORM_GO;
					end else begin
						state_d = rgcs_pkg::ST_MOD_GO;
					end
				end
			end
			rgcs_pkg::ST_PARALLEL: begin
				state_d = (fd_q[0] == '0 && fd_q[1] == '0) ? rgcs_pkg::ST_FINISH
					: rgcs_pkg::ST_FORM_GO;
			end
			rgcs_pkg::ST_MOD_GO: state_d = rgcs_pkg::ST_MOD_WAIT;
			rgcs_pkg::ST_MOD_WAIT: begin
				if (div_rsp.done) begin
					if (!fam_q && used_q[1]) begin
						state_d = rgcs_pkg::ST_FORM_GO;
					end else if (used_q == 2'b11) begin
						state_d = rgcs_pkg::ST_CMP_GO;
					end else begin
						state_d = rgcs_pkg::ST_MOVE_MUL_GO;
					end
				end
			end
			rgcs_pkg::ST_CMP_GO: state_d = rgcs_pkg::ST_CMP_WAIT;
			rgcs_pkg::ST_CMP_WAIT: begin
				if (mul_rsp.done) begin
					state_d = cmp_q ? rgcs_pkg::ST_MOVE_MUL_GO : rgcs_pkg::ST_CMP_GO;
				end
			end
			rgcs_pkg::ST_MOVE_MUL_GO: state_d = rgcs_pkg::ST_MOVE_MUL_WAIT;
			rgcs_pkg::ST_MOVE_MUL_WAIT: begin
				if (mul_rsp.done) begin
					state_d = rgcs_pkg::ST_MOVE_DIV_GO;
				end
			end
			rgcs_pkg::ST_MOVE_DIV_GO: state_d = rgcs_pkg::ST_MOVE_DIV_WAIT;
			rgcs_pkg::ST_MOVE_DIV_WAIT: begin
				if (div_rsp.done) begin
					if (!axis_q) begin
						state_d = rgcs_pkg::ST_MOVE_MUL_GO;
					end else begin
						state_d = next_more ? rgcs_pkg::ST_CHECK : rgcs_pkg::ST_FINISH;
					end
				end
			end
			rgcs_pkg::ST_FINISH: begin
				if (!result_valid_q || result_ready) begin
					state_d = rgcs_pkg::ST_IDLE;
				end
			end
			default: state_d = rgcs_pkg::ST_IDLE;
		endcase
	end

	// Outputs of the sequencer: handshake and unit requests.
	always_comb begin
		item_ready = (state_q == rgcs_pkg::ST_IDLE);
		mul_req.start = 1'b0;
		mul_req.a = {{(rgcs_pkg::MA_W-W){1'b0}}, rgcs_pkg::mag32(coef)};
		mul_req.b = rgcs_pkg::mag32(vcomp);
		div_req.start = 1'b0;
		div_req.n = {{(rgcs_pkg::DN_W-FV_W){1'b0}}, dd_mag};
		div_req.d = {{(rgcs_pkg::DD_W-W){1'b0}}, ds_f};
		case (state_q)
			rgcs_pkg::ST_FORM_GO: begin
				mul_req.start = 1'b1;
			end
			rgcs_pkg::ST_CMP_GO: begin
				mul_req.start = 1'b1;
				mul_req.a = cmp_q ? rgcs_pkg::magfv(fd_q[0]) : rgcs_pkg::magfv(fd_q[1]);
				mul_req.b = cmp_q ? m_q[1] : m_q[0];
			end
			rgcs_pkg::ST_MOVE_MUL_GO: begin
				mul_req.start = 1'b1;
				mul_req.a = {{(rgcs_pkg::MA_W-W){1'b0}}, rgcs_pkg::mag32(dir_ax)};
				mul_req.b = m_sel;
			end
			rgcs_pkg::ST_MOD_GO: begin
				div_req.start = 1'b1;
			end
			rgcs_pkg::ST_MOVE_DIV_GO: begin
				div_req.start = 1'b1;
				div_req.n = mul_rsp.p[rgcs_pkg::DN_W-1:0];
				div_req.d = half_q ? {q_sel, 1'b0} : {1'b0, q_sel};
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rgcs_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_a_q[0] <= rgcs_pkg::ONE_Q;
			coef_b_q[0] <= '0;
			offset_q[0] <= '0;
			spacing_q[0] <= rgcs_pkg::ONE_Q;
			coef_a_q[1] <= '0;
			coef_b_q[1] <= rgcs_pkg::ONE_Q;
			offset_q[1] <= '0;
			spacing_q[1] <= rgcs_pkg::ONE_Q;
		end else if (cfg_we) begin
			case (cfg_index[1:0])
				rgcs_pkg::FLD_COEF_A: coef_a_q[cfg_index[2]] <= cfg_data;
				rgcs_pkg::FLD_COEF_B: coef_b_q[cfg_index[2]] <= cfg_data;
				rgcs_pkg::FLD_OFFSET: offset_q[cfg_index[2]] <= cfg_data;
				rgcs_pkg::FLD_SPACING: spacing_q[cfg_index[2]] <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// Sequencer datapath.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sx_q <= '0;
			sy_q <= '0;
			dx_q <= '0;
			dy_q <= '0;
			fam_q <= 1'b0;
			term_q <= 1'b0;
			phase_fs_q <= 1'b0;
			axis_q <= 1'b0;
			cmp_q <= 1'b0;
			pass_q <= 1'b0;
			half_q <= 1'b0;
			next_cell_q <= 1'b0;
			corner_q <= 1'b0;
			err_q <= 1'b0;
			used_q <= '0;
			sel_q <= 1'b0;
			ddneg_q <= 1'b0;
			acc_q <= '0;
			fd_q[0] <= '0;
			fd_q[1] <= '0;
			m_q[0] <= '0;
			m_q[1] <= '0;
			p1_q <= '0;
		end else begin
			case (state_q)
				rgcs_pkg::ST_IDLE: begin
					if (item_acc) begin
						if (item.kind == rgcs_pkg::KIND_LOAD) begin
							sx_q <= item.start_x;
							sy_q <= item.start_y;
							dx_q <= item.dir_x;
							dy_q <= item.dir_y;
						end
						next_cell_q <= (item.kind == rgcs_pkg::KIND_NEXT_CELL);
						half_q <= (item.kind == rgcs_pkg::KIND_HALF);
						pass_q <= 1'b0;
						corner_q <= 1'b0;
						err_q <= 1'b0;
					end
				end
				rgcs_pkg::ST_CHECK: begin
					if (bad) begin
						err_q <= 1'b1;
					end
					fam_q <= 1'b0;
					term_q <= 1'b0;
					phase_fs_q <= 1'b0;
					acc_q <= '0;
				end
				rgcs_pkg::ST_FORM_WAIT: begin
					if (mul_rsp.done) begin
						if (!term_q) begin
							acc_q <= acc_nxt;
							term_q <= 1'b1;
						end else begin
							term_q <= 1'b0;
							if (!phase_fs_q) begin
								if (fam_q) begin
									fd_q[1] <= acc_nxt;
								end else begin
									fd_q[0] <= acc_nxt;
								end
								acc_q <= '0;
								fam_q <= 1'b1;
							end else begin
								acc_q <= acc_nxt;
							end
						end
					end
				end
				rgcs_pkg::ST_PARALLEL: begin
					used_q <= {fd_q[1] != '0, fd_q[0] != '0};
					if (fd_q[0] == '0 && fd_q[1] == '0) begin
						err_q <= 1'b1;
					end
					phase_fs_q <= 1'b1;
					fam_q <= (fd_q[0] == '0);
					term_q <= 1'b0;
					acc_q <= '0;
				end
				rgcs_pkg::ST_MOD_GO: begin
					ddneg_q <= dd_v[FV_W-1];
				end
				rgcs_pkg::ST_MOD_WAIT: begin
					if (div_rsp.done) begin
						if (fam_q) begin
							m_q[1] <= m_new;
						end else begin
							m_q[0] <= m_new;
						end
						sel_q <= fam_q;
						cmp_q <= 1'b0;
						axis_q <= 1'b0;
						if (!fam_q && used_q[1]) begin
							fam_q <= 1'b1;
							acc_q <= '0;
						end
					end
				end
				rgcs_pkg::ST_CMP_WAIT: begin
					if (mul_rsp.done) begin
						if (!cmp_q) begin
							p1_q <= mul_rsp.p;
							cmp_q <= 1'b1;
						end else begin
							sel_q <= !(p_lt || p_eq);
							if (p_eq && !half_q) begin
								corner_q <= 1'b1;
							end
						end
					end
				end
				rgcs_pkg::ST_MOVE_DIV_WAIT: begin
					if (div_rsp.done) begin
						if (axis_q) begin
							sy_q <= pos_sat;
							if (next_more) begin
								pass_q <= 1'b1;
								half_q <= 1'b1;
							end
						end else begin
							sx_q <= pos_sat;
							axis_q <= 1'b1;
						end
					end
				end
				default: begin
				end
			endcase
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
			result_q <= '0;
		end else begin
			if (fin_load) begin
				result_valid_q <= 1'b1;
				result_q.pos_x <= sx_q;
				result_q.pos_y <= sy_q;
				result_q.corner <= corner_q && !err_q;
				result_q.error <= err_q;
			end else if (result_ready) begin
				result_valid_q <= 1'b0;
			end
		end
	end

	assign result_valid = result_valid_q;
	assign result = result_q;

`ifndef ASSERT_OFF
	a_mul_done_expected: assert property (@(posedge clk) disable iff (!arst_n)
		mul_rsp.done |-> (state_q == rgcs_pkg::ST_FORM_WAIT
			|| state_q == rgcs_pkg::ST_CMP_WAIT
			|| state_q == rgcs_pkg::ST_MOVE_MUL_WAIT))
		else $error("multiplier finished while the sequencer was not waiting");

	a_div_done_expected: assert property (@(posedge clk) disable iff (!arst_n)
		div_rsp.done |-> (state_q == rgcs_pkg::ST_MOD_WAIT
			|| state_q == rgcs_pkg::ST_MOVE_DIV_WAIT))
		else $error("divider finished while the sequencer was not waiting");

	a_error_no_corner: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> !(result.error && result.corner))
		else $error("result beat flags both an error and a corner");

	a_load_direct: assert property (@(posedge clk) disable iff (!arst_n)
		(item_valid && item_ready && item.kind == rgcs_pkg::KIND_LOAD)
			|=> state_q == rgcs_pkg::ST_FINISH)
		else $error("load beat did not go straight to the result stage");
`endif

endmodule
